### rtl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg: shared definitions for the biquad IIR filter
// Default formats, register indexes and the control word that the sequencer
// hands to the datapath.
// ----------------------------------------------------------------------------
package bqd_pkg;

  // Default formats: Q1.15 samples and Q4.16 coefficients.
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_COEF_FRAC_BITS = 16;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int NUM_COEFS      = 5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [2:0] {
    MS_A1D1,
    MS_A2D2,
    MS_B0W0,
    MS_B1D1,
    MS_B2D2
  } mul_sel_t;

  // Accumulator operation.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD_P,
    ACC_SUB_P,
    ACC_ADD_P
  } acc_op_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     take_w;
    logic     take_y;
  } seq_ctrl_t;

endpackage

### rtl/bqd_mac.sv
// ----------------------------------------------------------------------------
// bqd_mac: shared multiply-accumulate unit
// One registered signed multiplier feeding a wide accumulator.
// ----------------------------------------------------------------------------
module bqd_mac #(
  parameter int SAMPLE_BITS    = bqd_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS,
  localparam int COEF_BITS     = COEF_FRAC_BITS + 4,
  localparam int DELAY_BITS    = SAMPLE_BITS + 8,
  localparam int PROD_BITS     = COEF_BITS + DELAY_BITS,
  localparam int ACC_BITS      = PROD_BITS + 2
) (
  input  logic                        clk,
  input  bqd_pkg::acc_op_t            acc_op,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [DELAY_BITS-1:0]  data,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [ACC_BITS-1:0]    acc
);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  x_ext;

  // The product is registered before it reaches the accumulator.
  always_ff @(posedge clk) begin
    prod <= coef * data;
  end

  assign prod_ext = ACC_BITS'(prod);
  assign x_ext    = ACC_BITS'(x) <<< COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    case (acc_op)
      bqd_pkg::ACC_LOAD_X: acc <= x_ext;
      bqd_pkg::ACC_LOAD_P: acc <= prod_ext;
      bqd_pkg::ACC_SUB_P:  acc <= acc - prod_ext;
      bqd_pkg::ACC_ADD_P:  acc <= acc + prod_ext;
      default:             acc <= acc;
    endcase
  end

endmodule

### rtl/bqd_seq.sv
// ----------------------------------------------------------------------------
// bqd_seq: step sequencer for the biquad
// Walks the feedback and feed-forward sums through the shared MAC.
// ----------------------------------------------------------------------------
module bqd_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               out_free,
  output logic               ready,
  output bqd_pkg::seq_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FB1,
    S_FB2,
    S_FB3,
    S_WRND,
    S_FF1,
    S_FF2,
    S_FF3,
    S_FF4,
    S_YOUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (start) state <= S_FB1;
        S_FB1:   state <= S_FB2;
        S_FB2:   state <= S_FB3;
        S_FB3:   state <= S_WRND;
        S_WRND:  state <= S_FF1;
        S_FF1:   state <= S_FF2;
        S_FF2:   state <= S_FF3;
        S_FF3:   state <= S_FF4;
        S_FF4:   state <= S_YOUT;
        S_YOUT:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready = (state == S_IDLE);

  always_comb begin
    ctrl.mul_sel = bqd_pkg::MS_A1D1;
    ctrl.acc_op  = bqd_pkg::ACC_HOLD;
    ctrl.take_w  = 1'b0;
    ctrl.take_y  = 1'b0;
    unique case (state)
      S_FB1: begin
        ctrl.acc_op = bqd_pkg::ACC_LOAD_X;
      end
      S_FB2: begin
        ctrl.mul_sel = bqd_pkg::MS_A2D2;
        ctrl.acc_op  = bqd_pkg::ACC_SUB_P;
      end
      S_FB3:  ctrl.acc_op = bqd_pkg::ACC_SUB_P;
      S_WRND: ctrl.take_w = 1'b1;
      S_FF1:  ctrl.mul_sel = bqd_pkg::MS_B0W0;
      S_FF2: begin
        ctrl.mul_sel = bqd_pkg::MS_B1D1;
        ctrl.acc_op  = bqd_pkg::ACC_LOAD_P;
      end
      S_FF3: begin
        ctrl.mul_sel = bqd_pkg::MS_B2D2;
        ctrl.acc_op  = bqd_pkg::ACC_ADD_P;
      end
      S_FF4:  ctrl.acc_op = bqd_pkg::ACC_ADD_P;
      S_YOUT: ctrl.take_y = out_free;
      default: ;
    endcase
  end

  // A started item always enters the first feedback step.
  assert property (@(posedge clk) disable iff (rst)
    (ready && start) |=> (state == S_FB1))
    else $error("sequencer did not begin an item after start");

endmodule

### rtl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter: second-order IIR filter, direct form II, fixed point
// One shared multiply-accumulate unit evaluates the feedback and
// feed-forward sums in turn, with rounding and saturation of each sum.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: sample_in (Q1.15)
//   m_axis    out        tdata: sample_out (Q1.15); tuser: clipped
//   cfg       in         cfg_index selects coef_b0..coef_a2, cfg_data Q4.16
//
// The single shared multiplier serves the five products in turn, and its
// product is registered before it reaches the accumulator; each of the two
// sums is then rounded, saturated and registered in a step of its own.
// s_tready is high only while the sequencer is idle, which it is from the
// commit of a result until a new item is accepted, so one item is in work at
// a time. The output register holds a finished item until it is taken; the
// last step waits there while the previous result is not yet taken.
// Synchronous reset returns the coefficients to b0 = 1.0 and the others to
// zero, and clears both delays and the output valid flag.
//
module biquad_iir_filter #(
  parameter int SAMPLE_BITS    = bqd_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = bqd_pkg::DEF_COEF_FRAC_BITS,
  localparam int COEF_BITS     = COEF_FRAC_BITS + 4,
  localparam int DELAY_BITS    = SAMPLE_BITS + 8,
  localparam int ACC_BITS      = COEF_BITS + DELAY_BITS + 2,
  localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [TDATA_BITS-1:0]               s_tdata,   // sample_in
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [TDATA_BITS-1:0]               m_tdata,   // sample_out
  output logic                                m_tuser,   // clipped
  // Coefficient write port.
  input  logic                                cfg_we,
  input  logic [bqd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COEF_BITS-1:0]                cfg_data
);

  localparam int RND_BITS = ACC_BITS + 1;

  // Saturation limits, sign-extended to the rounding width.
  localparam logic signed [RND_BITS-1:0] W_HI = RND_BITS'({1'b0, {(DELAY_BITS-1){1'b1}}});
  localparam logic signed [RND_BITS-1:0] W_LO = ~W_HI;
  localparam logic signed [RND_BITS-1:0] Y_HI = RND_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [RND_BITS-1:0] Y_LO = ~Y_HI;
  localparam logic signed [RND_BITS-1:0] HALF = RND_BITS'(1) <<< (COEF_FRAC_BITS - 1);

  // Coefficient registers.
  logic signed [COEF_BITS-1:0] coef_b0;
  logic signed [COEF_BITS-1:0] coef_b1;
  logic signed [COEF_BITS-1:0] coef_b2;
  logic signed [COEF_BITS-1:0] coef_a1;
  logic signed [COEF_BITS-1:0] coef_a2;

  // Filter state and the item in work.
  logic signed [DELAY_BITS-1:0]  delay_one;
  logic signed [DELAY_BITS-1:0]  delay_two;
  logic signed [DELAY_BITS-1:0]  w0;
  logic                          clip_w;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  // Datapath signals.
  bqd_pkg::seq_ctrl_t            ctrl;
  logic                          seq_ready;
  logic                          in_accept;
  logic                          out_free;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [DELAY_BITS-1:0]  mul_data;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [RND_BITS-1:0]    acc_rnd;
  logic signed [RND_BITS-1:0]    acc_shr;
  logic signed [DELAY_BITS-1:0]  w_sat;
  logic                          w_ovf;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_ovf;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = seq_ready;

  // Coefficient writes; indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_BITS'(1) <<< COEF_FRAC_BITS;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (bqd_pkg::cfg_reg_t'(cfg_index))
        bqd_pkg::REG_B0: coef_b0 <= cfg_data;
        bqd_pkg::REG_B1: coef_b1 <= cfg_data;
        bqd_pkg::REG_B2: coef_b2 <= cfg_data;
        bqd_pkg::REG_A1: coef_a1 <= cfg_data;
        bqd_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  bqd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .out_free (out_free),
    .ready    (seq_ready),
    .ctrl     (ctrl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl.mul_sel)
      bqd_pkg::MS_A1D1: begin
        mul_coef = coef_a1;
        mul_data = delay_one;
      end
      bqd_pkg::MS_A2D2: begin
        mul_coef = coef_a2;
        mul_data = delay_two;
      end
      bqd_pkg::MS_B0W0: begin
        mul_coef = coef_b0;
        mul_data = w0;
      end
      bqd_pkg::MS_B1D1: begin
        mul_coef = coef_b1;
        mul_data = delay_one;
      end
      bqd_pkg::MS_B2D2: begin
        mul_coef = coef_b2;
        mul_data = delay_two;
      end
      default: begin
        mul_coef = '0;
        mul_data = '0;
      end
    endcase
  end

  bqd_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .acc_op (ctrl.acc_op),
    .coef   (mul_coef),
    .data   (mul_data),
    .x      (x),
    .acc    (acc)
  );

  // Round half up, then floor shift back to the sample scale.
  assign acc_rnd = RND_BITS'(acc) + HALF;
  assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;

  always_comb begin
    w_ovf = (acc_shr > W_HI) || (acc_shr < W_LO);
    if (acc_shr > W_HI) begin
      w_sat = W_HI[DELAY_BITS-1:0];
    end else if (acc_shr < W_LO) begin
      w_sat = W_LO[DELAY_BITS-1:0];
    end else begin
      w_sat = acc_shr[DELAY_BITS-1:0];
    end
    y_ovf = (acc_shr > Y_HI) || (acc_shr < Y_LO);
    if (acc_shr > Y_HI) begin
      y_sat = Y_HI[SAMPLE_BITS-1:0];
    end else if (acc_shr < Y_LO) begin
      y_sat = Y_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = acc_shr[SAMPLE_BITS-1:0];
    end
  end

  // Payload registers for the item in work.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      x <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (ctrl.take_w) begin
      w0     <= w_sat;
      clip_w <= w_ovf;
    end
    if (ctrl.take_y) begin
      sample_out <= y_sat;
      clipped    <= clip_w || y_ovf;
    end
  end

  // The delays shift only once the result has been committed to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (ctrl.take_y) begin
        delay_two <= delay_one;
        delay_one <= w0;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = TDATA_BITS'($unsigned(sample_out));
  assign m_tuser = clipped;

  // An accepted item keeps the input closed while it is in work.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input reopened straight after an accepted item");

  // Committing a result shifts the delay line and presents the item.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.take_y |=> (m_tvalid && delay_one == $past(w0)
                     && delay_two == $past(delay_one)))
    else $error("delay shift or output valid wrong after commit");

  // A result is never committed over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.take_y |-> (!m_tvalid || m_tready))
    else $error("result committed over an item not yet taken");

endmodule
